>>> hw/rtl/gcsa_pkg.sv
package gcsa_pkg;

	localparam int MAX_ROWS   = 1024;
	localparam int MAX_GROUPS = 64;
	localparam int DEPTH      = MAX_ROWS * MAX_GROUPS;
	localparam int ADDR_W     = $clog2(DEPTH);

	localparam int CMD_W     = 2;
	localparam int ROW_W     = 10;
	localparam int GRP_W     = 7;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int ROWS_CFG_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CMD_W-1:0] CMD_ACC      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ_CLR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_GROUP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ROW   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUPS = 1'd1;

	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET   = 11'd1024;
	localparam logic [GRP_W-1:0]      GROUPS_RESET = 7'd64;

	typedef struct packed {
		logic              busy;
		logic [ADDR_W-1:0] addr;
	} clr_t;

endpackage

>>> hw/rtl/gcsa_if.sv
interface gcsa_req_if;
	import gcsa_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [ROW_W-1:0]        row;
	logic [GRP_W-1:0]        group;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, cmd, row, group, value, input ready);
	modport sink   (input valid, cmd, row, group, value, output ready);
endinterface

interface gcsa_rsp_if;
	import gcsa_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sum;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, sum, status, input ready);
	modport sink   (input valid, sum, status, output ready);
endinterface

>>> hw/rtl/gcsa_ram.sv
module gcsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/gcsa_clear.sv
module gcsa_clear (
	input  logic          clk,
	input  logic          arst_n,
	output gcsa_pkg::clr_t clr
);
	import gcsa_pkg::*;

	logic              busy_q;
	logic [ADDR_W-1:0] addr_q;

	// one entry per cycle, starting right after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			if (addr_q == ADDR_W'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			addr_q <= addr_q + ADDR_W'(1);
		end
	end

	assign clr.busy = busy_q;
	assign clr.addr = addr_q;

endmodule

>>> hw/rtl/grouped_column_sum_accumulator_top.sv
// Group-by scatter-add engine. Keeps a table of signed 32-bit sums indexed by
// (group label, row) in one synchronous RAM.
// req channel: cmd (accumulate / read and clear / read), row, 1-based group
// label and value. rsp channel: one result per request, sum and status.
// Config port: cfg_we with cfg_index 0 = rows in use, 1 = groups in use;
// write only while the block is idle.
// Pipeline: a taken request passes the s1 register, then the output register.
// Throughput is one request per cycle unless rsp.ready stalls: the RAM is read
// at the accept edge and written back as the request leaves s1; a back-to-back
// request to the same entry picks up the value being written, not RAM data.
// Reset: a clearing pass zeros all 65536 entries, one per cycle; req.ready
// stays low until the pass ends. Config writes are taken during it.
// Stall: when rsp.ready is low with a result pending, the request in flight
// holds and req.ready drops until the output register drains.
// Bad group labels and out-of-range rows return status with sum 0 and leave
// the table untouched; accumulates saturate at the 32-bit signed limits.
module grouped_column_sum_accumulator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	gcsa_req_if.sink                       req,
	gcsa_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [gcsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gcsa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gcsa_pkg::*;

	logic [ROWS_CFG_W-1:0] rows_q;
	logic [GRP_W-1:0]      groups_q;

	clr_t clr;

	logic                     v_s1;
	logic [CMD_W-1:0]         cmd_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic [STATUS_W-1:0]      chk_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic                     fwd_hit_s1;
	logic [DATA_W-1:0]        fwd_data_s1;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_sum_q;
	logic [STATUS_W-1:0]      out_status_q;

	logic                     accept;
	logic                     s1_adv;
	logic                     bad_group;
	logic                     bad_row;
	logic [STATUS_W-1:0]      chk_in;
	logic [ADDR_W-1:0]        addr_in;
	logic [DATA_W-1:0]        rdata;
	logic signed [DATA_W-1:0] cur;
	logic signed [DATA_W:0]   add_wide;
	logic signed [DATA_W-1:0] acc_sat;
	logic                     sat;
	logic                     upd_we;
	logic [DATA_W-1:0]        upd_data;
	logic signed [DATA_W-1:0] res_sum;
	logic [STATUS_W-1:0]      res_status;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_RESET;
			groups_q <= GROUPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS:   rows_q   <= cfg_data[ROWS_CFG_W-1:0];
				CFG_GROUPS: groups_q <= cfg_data[GRP_W-1:0];
				default:    ;
			endcase
		end
	end

	gcsa_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	// --- request checks and address ---
	assign bad_group = (req.group == '0) || (req.group > groups_q) ||
		(32'(req.group) > 32'(MAX_GROUPS));
	assign bad_row = ({1'b0, req.row} >= rows_q) || (32'(req.row) >= 32'(MAX_ROWS));
	assign chk_in = bad_group ? ST_BAD_GROUP : (bad_row ? ST_BAD_ROW : ST_OK);
	assign addr_in = ADDR_W'((ADDR_W'(req.group) - ADDR_W'(1)) * ADDR_W'(MAX_ROWS))
		+ ADDR_W'(req.row);

	assign s1_adv    = !out_valid_q || rsp.ready;
	assign req.ready = !clr.busy && (!v_s1 || s1_adv);
	assign accept    = req.valid && req.ready;

	// --- read-modify-write ---
	assign cur      = fwd_hit_s1 ? fwd_data_s1 : rdata;
	assign add_wide = {cur[DATA_W-1], cur} + {value_s1[DATA_W-1], value_s1};
	assign sat      = add_wide[DATA_W] != add_wide[DATA_W-1];
	assign acc_sat  = !sat ? add_wide[DATA_W-1:0] :
		(add_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});

	always_comb begin
		upd_we     = 1'b0;
		upd_data   = '0;
		res_sum    = '0;
		res_status = chk_s1;
		if (chk_s1 == ST_OK) begin
			case (cmd_s1)
				CMD_ACC: begin
					upd_we     = 1'b1;
					upd_data   = acc_sat;
					res_sum    = acc_sat;
					res_status = sat ? ST_SATURATED : ST_OK;
				end
				CMD_READ_CLR: begin
					upd_we  = 1'b1;
					res_sum = cur;
				end
				default: begin
					res_sum = cur;
				end
			endcase
		end
	end

	assign ram_we    = clr.busy || (v_s1 && s1_adv && upd_we);
	assign ram_waddr = clr.busy ? clr.addr : addr_s1;
	assign ram_wdata = clr.busy ? '0 : upd_data;

	gcsa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (addr_in),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= req.cmd;
			addr_s1  <= addr_in;
			chk_s1   <= chk_in;
			value_s1 <= req.value;
			// the entry being written this edge is stale in the RAM read
			fwd_hit_s1  <= v_s1 && s1_adv && upd_we && (addr_s1 == addr_in);
			fwd_data_s1 <= upd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s1_adv) begin
			out_sum_q    <= res_sum;
			out_status_q <= res_status;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.sum    = out_sum_q;
	assign rsp.status = out_status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		clr.busy |-> !accept)
		else $error("request taken during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_adv |=> v_s1 && $stable(addr_s1))
		else $error("request in flight lost while output stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_BAD_GROUP || rsp.status == ST_BAD_ROW)
		|-> rsp.sum == '0)
		else $error("rejected request returned nonzero sum");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && !clr.busy |-> v_s1 && chk_s1 == ST_OK)
		else $error("table written by a rejected request");

endmodule

>>> sim/grouped_column_sum_accumulator_top_tb.sv
`timescale 1ns / 100ps

module grouped_column_sum_accumulator_top_tb;
	import gcsa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused code, behaves as a plain read
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [ROW_W-1:0]         row;
		logic [GRP_W-1:0]         group;
		logic signed [DATA_W-1:0] value;
	} sum_request_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sum;
		logic [STATUS_W-1:0]      status;
	} sum_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gcsa_req_if req_ch ();
	gcsa_rsp_if rsp_ch ();

	grouped_column_sum_accumulator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the block's table and registers
	logic signed [DATA_W-1:0] sum_table [DEPTH];
	logic [ROWS_CFG_W-1:0] rows_cfg;
	logic [GRP_W-1:0] groups_cfg;

	sum_request_t pending_reqs[$];
	sum_result_t expected_sums[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit pressure_armed = 1'b0;
	bit pressure_done = 1'b0;
	int hold_left = 0;
	logic req_taken = 1'b0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("grouped_column_sum_accumulator_top regression: fail");
			$finish;
		end
	end

	function automatic void note_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Computes the result of one request and applies it to the shadow table.
	function automatic sum_result_t apply_request(input sum_request_t r);
		sum_result_t res;
		int addr;
		longint total;
		res.sum = '0;
		res.status = ST_OK;
		if (r.group == 0 || r.group > groups_cfg || r.group > MAX_GROUPS) begin
			res.status = ST_BAD_GROUP;
		end else if (r.row >= rows_cfg || r.row >= MAX_ROWS) begin
			res.status = ST_BAD_ROW;
		end else begin
			addr = (int'(r.group) - 1) * MAX_ROWS + int'(r.row);
			if (r.cmd == CMD_ACC) begin
				total = longint'(sum_table[addr]) + longint'(r.value);
				if (total > SUM_MAX) begin
					total = SUM_MAX;
					res.status = ST_SATURATED;
				end else if (total < SUM_MIN) begin
					total = SUM_MIN;
					res.status = ST_SATURATED;
				end
				sum_table[addr] = total[DATA_W-1:0];
				res.sum = total[DATA_W-1:0];
			end else begin
				res.sum = sum_table[addr];
				if (r.cmd == CMD_READ_CLR)
					sum_table[addr] = '0;
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		sum_request_t r;
		sum_result_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				r.cmd = req_ch.cmd;
				r.row = req_ch.row;
				r.group = req_ch.group;
				r.value = req_ch.value;
				expected_sums.push_back(apply_request(r));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_sums.size() == 0) begin
					note_mismatch($sformatf("unexpected result sum=%0d status=%0d",
						rsp_ch.sum, rsp_ch.status));
				end else begin
					want = expected_sums.pop_front();
					if (rsp_ch.sum !== want.sum)
						note_mismatch($sformatf("sum: expected %0d, got %0d",
							want.sum, rsp_ch.sum));
					if (rsp_ch.status !== want.status)
						note_mismatch($sformatf("status: expected %0d, got %0d",
							want.status, rsp_ch.status));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (req_taken)
			void'(pending_reqs.pop_front());
		if (!req_ch.valid || req_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_ch.valid <= 1'b1;
				req_ch.cmd <= pending_reqs[0].cmd;
				req_ch.row <= pending_reqs[0].row;
				req_ch.group <= pending_reqs[0].group;
				req_ch.value <= pending_reqs[0].value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// one long hold-off so the block backs up and drops req.ready
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (pressure_armed && !pressure_done && pending_reqs.size() <= 80) begin
			pressure_done <= 1'b1;
			hold_left <= 300;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_request(input logic [CMD_W-1:0] cmd, input int row, input int group,
			input logic signed [DATA_W-1:0] value);
		sum_request_t r;
		r.cmd = cmd;
		r.row = row[ROW_W-1:0];
		r.group = group[GRP_W-1:0];
		r.value = value;
		pending_reqs.push_back(r);
	endtask

	function automatic sum_request_t random_request();
		sum_request_t r;
		int pick;
		int row_span;
		int grp_span;
		row_span = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
		grp_span = (groups_cfg > MAX_GROUPS) ? MAX_GROUPS : int'(groups_cfg);
		r.cmd = CMD_W'($urandom_range(3));
		r.row = ROW_W'($urandom_range(MAX_ROWS - 1));
		r.group = GRP_W'($urandom_range(127));
		r.value = $urandom;
		if ($urandom_range(99) < 12 || row_span == 0 || grp_span == 0)
			return r;

		pick = $urandom_range(99);
		if (pick < 55)
			r.cmd = CMD_ACC;
		else if (pick < 75)
			r.cmd = CMD_READ_CLR;
		else if (pick < 95)
			r.cmd = CMD_READ;
		else
			r.cmd = CMD_SPARE;

		// mostly a few hot entries so sums build up and saturate
		pick = $urandom_range(99);
		if (pick < 60)
			r.row = ROW_W'($urandom_range((row_span < 4) ? row_span - 1 : 3));
		else if (pick < 70)
			r.row = ROW_W'(row_span - 1);
		else
			r.row = ROW_W'($urandom_range(row_span - 1));
		pick = $urandom_range(99);
		if (pick < 60)
			r.group = GRP_W'(1 + $urandom_range((grp_span < 3) ? grp_span - 1 : 2));
		else if (pick < 70)
			r.group = GRP_W'(grp_span);
		else
			r.group = GRP_W'(1 + $urandom_range(grp_span - 1));

		pick = $urandom_range(99);
		if (pick < 65)
			r.value = $signed($urandom_range(2000)) - 1000;
		else if (pick < 80)
			r.value = 32'h7FFF_FFFF - $urandom_range(255);
		else if (pick < 92)
			r.value = 32'h8000_0000 + $urandom_range(255);
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_sums.size() != 0)
			@(posedge clk);
		// the result register lags behind the request
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		if (idx == CFG_ROWS)
			rows_cfg = data[ROWS_CFG_W-1:0];
		else
			groups_cfg = data[GRP_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_phase(input int rows, input int groups, input int send_pct,
			input int recv_pct, input int count, input bit squeeze);
		wait_drained();
		write_register(CFG_ROWS, rows[CFG_DATA_W-1:0]);
		write_register(CFG_GROUPS, groups[CFG_DATA_W-1:0]);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		pressure_armed = squeeze;
		repeat (count)
			pending_reqs.push_back(random_request());
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_ACC;
		req_ch.row = '0;
		req_ch.group = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = '0;
		rows_cfg = ROWS_RESET;
		groups_cfg = GROUPS_RESET;
		for (int i = 0; i < DEPTH; i++)
			sum_table[i] = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: limits, saturation both ways, clears, bad labels, same-entry chains
		queue_request(CMD_ACC, 0, 1, 32'h7FFF_FFFF);
		queue_request(CMD_ACC, 0, 1, 1);
		queue_request(CMD_READ, 0, 1, 32'hFFFF_FFFF);
		queue_request(CMD_READ_CLR, 0, 1, 0);
		queue_request(CMD_READ, 0, 1, 0);
		queue_request(CMD_ACC, MAX_ROWS - 1, MAX_GROUPS, 32'h8000_0000);
		queue_request(CMD_ACC, MAX_ROWS - 1, MAX_GROUPS, -1);
		queue_request(CMD_SPARE, MAX_ROWS - 1, MAX_GROUPS, 5);
		queue_request(CMD_READ_CLR, MAX_ROWS - 1, MAX_GROUPS, 0);
		queue_request(CMD_ACC, 5, 0, 7);
		queue_request(CMD_ACC, 5, MAX_GROUPS + 1, 7);
		queue_request(CMD_READ, MAX_ROWS - 1, 127, 0);
		queue_request(CMD_READ_CLR, 5, 0, 0);
		queue_request(CMD_ACC, 2, 2, 5);
		queue_request(CMD_ACC, 2, 2, -3);
		queue_request(CMD_ACC, 2, 2, 32'h7FFF_FFFF);
		queue_request(CMD_ACC, 2, 2, 32'h8000_0000);
		queue_request(CMD_READ_CLR, 2, 2, 0);
		queue_request(CMD_ACC, 2, 2, 9);
		queue_request(CMD_READ, 2, 2, 32'h5555_AAAA);
		queue_request(CMD_ACC, 512, 33, 32'hAAAA_5555);
		queue_request(CMD_READ, 512, 33, 0);

		//        rows  groups send recv count squeeze
		run_phase(1024, 64,    0,   0,   120,  1'b1);
		run_phase(1,    1,     82,  0,   110,  1'b0);
		run_phase(16,   4,     0,   82,  110,  1'b0);
		run_phase(0,    64,    36,  36,  40,   1'b0);
		run_phase(2047, 127,   0,   0,   110,  1'b0);
		run_phase(1024, 0,     82,  0,   30,   1'b0);
		run_phase(700,  37,    0,   82,  110,  1'b0);
		run_phase(8,    3,     36,  36,  110,  1'b0);
		run_phase(1023, 63,    36,  36,  110,  1'b0);
		wait_drained();
		repeat (10) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("grouped_column_sum_accumulator_top regression: pass");
		end else begin
			$display("grouped_column_sum_accumulator_top regression: fail");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/gcsa_pkg.sv
hw/rtl/gcsa_if.sv
hw/rtl/gcsa_ram.sv
hw/rtl/gcsa_clear.sv
hw/rtl/grouped_column_sum_accumulator_top.sv
sim/grouped_column_sum_accumulator_top_tb.sv
